// ----- hdl/jjji_pkg.sv -----
// ----------------------------------------------------------------------------
// jjji_pkg: shared types, constants and arithmetic helpers
// Payload structs, register codes, joint limits and the fixed-point helpers
// used by the jog integrator lanes and the top level.
// ----------------------------------------------------------------------------
package jjji_pkg;

	localparam int ARM_JOINTS_DEF = 5;
	localparam int MAX_ARM        = 5;
	localparam int NSLOT          = 6;
	localparam int GRIP_SLOT      = 5;

	localparam int CFG_W     = 15;
	localparam int CFG_IDX_W = 2;

	localparam int PROD_W  = 30;
	localparam int DELTA_W = 13;
	localparam int RATE_W  = 17;

	localparam logic [14:0] DEADZONE_RST     = 15'd4915;
	localparam logic [11:0] JOINT_STEP_RST   = 12'd111;
	localparam logic [11:0] GRIPPER_STEP_RST = 12'd98;
	localparam logic [11:0] MIN_GOAL_RST     = 12'd4;

	localparam logic ACT_REPORT = 1'b0;
	localparam logic ACT_TICK   = 1'b1;

	localparam logic signed [RATE_W-1:0] RATE_FULL = 17'sd32768;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DEADZONE     = 2'd0,
		CFG_JOINT_STEP   = 2'd1,
		CFG_GRIPPER_STEP = 2'd2,
		CFG_MIN_GOAL     = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		XS_IDLE,
		XS_EVAL,
		XS_COMMIT
	} xstate_t;

	typedef struct packed {
		logic               action;
		logic [2:0]         joint_index;
		logic signed [15:0] joint_position;
		logic               joy_present;
		logic signed [15:0] stick_left_x;
		logic signed [15:0] stick_left_y;
		logic signed [15:0] stick_right_x;
		logic signed [15:0] stick_right_y;
		logic signed [15:0] trigger_left;
		logic signed [15:0] trigger_right;
		logic               bumper_left;
		logic               bumper_right;
	} in_item_t;

	typedef struct packed {
		logic               arm_goal_valid;
		logic signed [15:0] shoulder_rotate_target;
		logic signed [15:0] shoulder_pitch_target;
		logic signed [15:0] elbow_target;
		logic signed [15:0] wrist_pitch_target;
		logic signed [15:0] wrist_roll_target;
		logic               gripper_goal_valid;
		logic signed [15:0] gripper_target;
	} out_item_t;

	// Per-cycle controls that the top level hands to every lane.
	typedef struct packed {
		logic ld1;
		logic ld2;
		logic ld3;
		logic ld4;
		logic eval;
		logic commit;
		logic active;
		logic arm_send;
		logic held_valid;
	} jjji_lane_ctl_t;

	typedef struct packed {
		logic active;
		logic reach;
	} jjji_merge_t;

	function automatic logic signed [15:0] limit_lo(input logic [2:0] slot);
		logic signed [15:0] r;
		case (slot)
			3'd0:    r = -16'sd8028;
			3'd1:    r = -16'sd7148;
			3'd2:    r = -16'sd6144;
			3'd3:    r = -16'sd6791;
			3'd4:    r = -16'sd11264;
			3'd5:    r = -16'sd734;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] limit_hi(input logic [2:0] slot);
		logic signed [15:0] r;
		case (slot)
			3'd0:    r = 16'sd8028;
			3'd1:    r = 16'sd7148;
			3'd2:    r = 16'sd6144;
			3'd3:    r = 16'sd6791;
			3'd4:    r = 16'sd11264;
			3'd5:    r = 16'sd6434;
			default: r = '0;
		endcase
		return r;
	endfunction

	function automatic logic signed [15:0] clamp_slot(input logic signed [16:0] v,
		input logic [2:0] slot);
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic signed [15:0] r;
		lo = limit_lo(slot);
		hi = limit_hi(slot);
		if (v < 17'(lo)) begin
			r = lo;
		end else if (v > 17'(hi)) begin
			r = hi;
		end else begin
			r = 16'(v);
		end
		return r;
	endfunction

	// An axis whose magnitude is below the deadzone reads zero.
	function automatic logic signed [15:0] dz_axis(input logic signed [15:0] v,
		input logic [14:0] dz);
		logic [16:0] mag;
		mag = v[15] ? 17'(-(17'(v))) : 17'(v);
		return (mag < {2'b00, dz}) ? 16'sd0 : v;
	endfunction

	function automatic logic signed [RATE_W-1:0] lane_rate(input in_item_t it,
		input int lane, input logic [14:0] dz);
		logic signed [RATE_W-1:0] r;
		case (lane)
			0: r = RATE_W'(dz_axis(it.stick_left_x, dz));
			1: r = RATE_W'(dz_axis(it.stick_left_y, dz));
			2: r = RATE_W'(dz_axis(it.stick_right_y, dz));
			3: r = RATE_W'(dz_axis(it.stick_right_x, dz));
			4: begin
				if (it.bumper_right && !it.bumper_left) begin
					r = RATE_FULL;
				end else if (it.bumper_left && !it.bumper_right) begin
					r = -RATE_FULL;
				end else begin
					r = '0;
				end
			end
			default: r = '0;
		endcase
		return r;
	endfunction

	// Divide by 2^sh, rounding to nearest with ties away from zero.
	function automatic logic signed [DELTA_W-1:0] round_shift(
		input logic signed [PROD_W-1:0] p, input int sh);
		logic [PROD_W-1:0] mag;
		logic [PROD_W-1:0] q;
		logic signed [DELTA_W-1:0] qs;
		mag = p[PROD_W-1] ? PROD_W'(-p) : PROD_W'(p);
		q = (mag + (PROD_W'(1) << (sh - 1))) >> sh;
		qs = signed'(q[DELTA_W-1:0]);
		return p[PROD_W-1] ? -qs : qs;
	endfunction

endpackage

// ----- hdl/joystick_joint_jog_integrator_core.sv -----
// ----------------------------------------------------------------------------
// joystick_joint_jog_integrator_core: joint jog integrator for arm and gripper
// A tick passes stages s1, s2 and s3, the shared state stage and the output
// register. The three front stages take an item every cycle unless the state
// stage holds them back; it ends a report or a dropped tick in evaluate and an
// evaluated tick after evaluate, then commit, where a sending commit waits
// while out_stall holds a result. Reset restores register defaults, clears the
// measured positions and known flags and drops the held target.
// ----------------------------------------------------------------------------
module joystick_joint_jog_integrator_core #(
	parameter int ARM_JOINTS = jjji_pkg::ARM_JOINTS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  jjji_pkg::in_item_t             in_item,
	output logic                           out_valid,
	input  logic                           out_stall,
	output jjji_pkg::out_item_t            out_item,
	input  logic                           cfg_we,
	input  logic [jjji_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [jjji_pkg::CFG_W-1:0]     cfg_data
);
	import jjji_pkg::*;

	localparam int LANES = (ARM_JOINTS < MAX_ARM) ? ARM_JOINTS : MAX_ARM;

	typedef struct packed {
		logic               action;
		logic [2:0]         joint_index;
		logic signed [15:0] joint_position;
		logic               joy_present;
	} tag_t;

	// Configuration
	logic [14:0] dz_q;
	logic [11:0] jstep_q;
	logic [11:0] gstep_q;
	logic [11:0] min_step_q;

	// Front pipeline
	logic v_s1, v_s2, v_s3;
	tag_t tag_s1, tag_s2, tag_s3, tag_s4;
	logic signed [16:0]        n_s1;
	logic signed [PROD_W-1:0]  gprod_s2;
	logic                      gok_s2;
	logic signed [DELTA_W-1:0] gd_s3, gd_s4;
	logic                      gok_s3, gok_s4;
	logic [16:0]               gabs;

	// State
	xstate_t            x_state, x_next;
	logic signed [15:0] meas_q [NSLOT];
	logic [NSLOT-1:0]   known_q;
	logic               held_valid_q;
	logic signed [15:0] gtgt_q;
	logic               gsend_q;
	logic signed [16:0] gsum;

	// Output register
	logic      out_valid_q;
	out_item_t out_item_q;

	// Flow control
	logic free1, free2, free3, x_free;
	logic in_acc, ld2, ld3, x_load;
	logic x_done, eval, commit, meas_we, out_free;
	logic all_known, arm_send, grip_send, send;

	jjji_lane_ctl_t          lctl;
	jjji_merge_t             mres;
	logic [LANES-1:0]        lane_nz;
	logic [LANES-1:0][15:0]  lane_adiff;
	logic [LANES-1:0][15:0]  lane_tgt;
	logic signed [15:0]      tgt5 [MAX_ARM];

	// ---------------- flow control ----------------
	assign out_free = !out_valid_q || !out_stall;
	assign free3    = !v_s3 || x_free;
	assign free2    = !v_s2 || free3;
	assign free1    = !v_s1 || free2;
	assign in_stall = !free1;
	assign in_acc   = in_valid && free1;
	assign ld2      = v_s1 && free2;
	assign ld3      = v_s2 && free3;
	assign x_load   = v_s3 && x_free;

	assign all_known = &known_q[LANES-1:0];
	assign arm_send  = mres.active && mres.reach;
	assign grip_send = gsend_q && (!mres.active || mres.reach);
	assign send      = arm_send || grip_send;

	always_comb begin
		x_next  = x_state;
		x_done  = 1'b0;
		eval    = 1'b0;
		commit  = 1'b0;
		meas_we = 1'b0;
		case (x_state)
			XS_IDLE: begin
			end
			XS_EVAL: begin
				if (tag_s4.action == ACT_REPORT) begin
					x_done  = 1'b1;
					meas_we = (tag_s4.joint_index < 3'(NSLOT));
				end else if (!tag_s4.joy_present || !all_known) begin
					x_done = 1'b1;
				end else begin
					eval   = 1'b1;
					x_next = XS_COMMIT;
				end
			end
			XS_COMMIT: begin
				if (!send || out_free) begin
					x_done = 1'b1;
					commit = 1'b1;
				end
			end
			default: begin
				x_next = XS_IDLE;
			end
		endcase
		x_free = (x_state == XS_IDLE) || x_done;
		if (x_free) begin
			x_next = v_s3 ? XS_EVAL : XS_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_state <= XS_IDLE;
		end else begin
			x_state <= x_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_acc || (v_s1 && !free2);
			v_s2 <= ld2 || (v_s2 && !free3);
			v_s3 <= ld3 || (v_s3 && !x_free);
		end
	end

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dz_q       <= DEADZONE_RST;
			jstep_q    <= JOINT_STEP_RST;
			gstep_q    <= GRIPPER_STEP_RST;
			min_step_q <= MIN_GOAL_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_DEADZONE:     dz_q       <= cfg_data[14:0];
				CFG_JOINT_STEP:   jstep_q    <= cfg_data[11:0];
				CFG_GRIPPER_STEP: gstep_q    <= cfg_data[11:0];
				CFG_MIN_GOAL:     min_step_q <= cfg_data[11:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- gripper front path ----------------
	assign gabs = n_s1[16] ? 17'(-n_s1) : 17'(n_s1);

	always_ff @(posedge clk) begin
		if (in_acc) begin
			tag_s1.action         <= in_item.action;
			tag_s1.joint_index    <= in_item.joint_index;
			tag_s1.joint_position <= in_item.joint_position;
			tag_s1.joy_present    <= in_item.joy_present;
			n_s1 <= 17'(dz_axis(in_item.trigger_left, dz_q))
				- 17'(dz_axis(in_item.trigger_right, dz_q));
		end
		if (ld2) begin
			tag_s2   <= tag_s1;
			gprod_s2 <= PROD_W'(n_s1) * PROD_W'($signed({1'b0, gstep_q}));
			gok_s2   <= (gabs >= {1'b0, dz_q, 1'b0});
		end
		if (ld3) begin
			tag_s3 <= tag_s2;
			gd_s3  <= round_shift(gprod_s2, 16);
			gok_s3 <= gok_s2;
		end
		if (x_load) begin
			tag_s4 <= tag_s3;
			gd_s4  <= gd_s3;
			gok_s4 <= gok_s3;
		end
	end

	// ---------------- measured state and gripper evaluation ----------------
	assign gsum = 17'(meas_q[GRIP_SLOT]) + 17'(gd_s4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NSLOT; i++) begin
				meas_q[i] <= '0;
			end
			known_q      <= '0;
			held_valid_q <= 1'b0;
		end else begin
			if (meas_we) begin
				meas_q[tag_s4.joint_index]  <= tag_s4.joint_position;
				known_q[tag_s4.joint_index] <= 1'b1;
			end
			if (commit) begin
				held_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (eval) begin
			gtgt_q  <= clamp_slot(gsum, 3'(GRIP_SLOT));
			gsend_q <= known_q[GRIP_SLOT] && gok_s4;
		end
	end

	// ---------------- lanes and merge ----------------
	always_comb begin
		lctl.ld1        = in_acc;
		lctl.ld2        = ld2;
		lctl.ld3        = ld3;
		lctl.ld4        = x_load;
		lctl.eval       = eval;
		lctl.commit     = commit;
		lctl.active     = mres.active;
		lctl.arm_send   = arm_send;
		lctl.held_valid = held_valid_q;
	end

	for (genvar g = 0; g < LANES; g++) begin : g_lane
		jjji_lane #(
			.LANE (g)
		) u_lane (
			.clk   (clk),
			.item  (in_item),
			.dz    (dz_q),
			.step  (jstep_q),
			.ctl   (lctl),
			.meas  (meas_q[g]),
			.nz    (lane_nz[g]),
			.adiff (lane_adiff[g]),
			.tgt   (lane_tgt[g])
		);
	end

	jjji_merge #(
		.LANES (LANES)
	) u_merge (
		.adiff    (lane_adiff),
		.nz       (lane_nz),
		.min_step (min_step_q),
		.res      (mres)
	);

	for (genvar g = 0; g < MAX_ARM; g++) begin : g_tgt
		if (g < LANES) begin : g_used
			assign tgt5[g] = lane_tgt[g];
		end else begin : g_unused
			assign tgt5[g] = '0;
		end
	end

	// ---------------- output register ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= (commit && send) || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (commit && send) begin
			out_item_q.arm_goal_valid         <= arm_send;
			out_item_q.shoulder_rotate_target <= arm_send ? tgt5[0] : '0;
			out_item_q.shoulder_pitch_target  <= arm_send ? tgt5[1] : '0;
			out_item_q.elbow_target           <= arm_send ? tgt5[2] : '0;
			out_item_q.wrist_pitch_target     <= arm_send ? tgt5[3] : '0;
			out_item_q.wrist_roll_target      <= arm_send ? tgt5[4] : '0;
			out_item_q.gripper_goal_valid     <= grip_send;
			out_item_q.gripper_target         <= grip_send ? gtgt_q : '0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_item_q;

	// ---------------- assertions ----------------
	a_result_has_goal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_item.arm_goal_valid || out_item.gripper_goal_valid))
		else $error("result transfer carries neither an arm nor a gripper goal");

	a_commit_after_eval: assert property (@(posedge clk) disable iff (!arst_n)
		(x_state == XS_COMMIT) |-> $past(x_state == XS_EVAL || x_state == XS_COMMIT))
		else $error("commit phase entered without an evaluation");

	a_held_stays_valid: assert property (@(posedge clk) disable iff (!arst_n)
		!$fell(held_valid_q))
		else $error("held target lost its valid flag");

	a_unsent_arm_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_item.arm_goal_valid) |->
		(out_item.shoulder_rotate_target == '0 && out_item.wrist_roll_target == '0))
		else $error("arm target fields not cleared on a gripper-only result");

endmodule

// ----- hdl/jjji_lane.sv -----
// ----------------------------------------------------------------------------
// jjji_lane: one arm joint of the jog integrator
// Deadzones its axis (lane 4: bumpers), scales by the joint step, rounds; at
// evaluation steps the held target, clamps to joint limits, measures the move.
// ----------------------------------------------------------------------------
module jjji_lane #(
	parameter int LANE = 0
) (
	input  logic                     clk,
	input  jjji_pkg::in_item_t       item,
	input  logic [14:0]              dz,
	input  logic [11:0]              step,
	input  jjji_pkg::jjji_lane_ctl_t ctl,
	input  logic signed [15:0]       meas,
	output logic                     nz,
	output logic [15:0]              adiff,
	output logic signed [15:0]       tgt
);
	import jjji_pkg::*;

	logic signed [RATE_W-1:0]  rate;
	logic signed [PROD_W-1:0]  prod_s1;
	logic                      nz_s1;
	logic signed [DELTA_W-1:0] d_s2;
	logic                      nz_s2;
	logic signed [DELTA_W-1:0] d_s3;
	logic                      nz_s3;
	logic signed [DELTA_W-1:0] d_s4;
	logic                      nz_s4;

	logic signed [15:0] base;
	logic signed [16:0] sum;
	logic signed [15:0] tgt_new;
	logic signed [16:0] diff;

	logic signed [15:0] base_q;
	logic signed [15:0] tgt_q;
	logic [15:0]        adiff_q;
	logic signed [15:0] held_q;

	assign rate = lane_rate(item, LANE, dz);

	always_comb begin
		base    = ctl.held_valid ? held_q : meas;
		sum     = 17'(base) + 17'(d_s4);
		tgt_new = clamp_slot(sum, 3'(LANE));
		diff    = 17'(tgt_new) - 17'(base);
	end

	always_ff @(posedge clk) begin
		if (ctl.ld1) begin
			prod_s1 <= PROD_W'(rate) * PROD_W'($signed({1'b0, step}));
			nz_s1   <= (rate != '0);
		end
		if (ctl.ld2) begin
			d_s2  <= round_shift(prod_s1, 15);
			nz_s2 <= nz_s1;
		end
		if (ctl.ld3) begin
			d_s3  <= d_s2;
			nz_s3 <= nz_s2;
		end
		if (ctl.ld4) begin
			d_s4  <= d_s3;
			nz_s4 <= nz_s3;
		end
		if (ctl.eval) begin
			base_q  <= base;
			tgt_q   <= tgt_new;
			adiff_q <= diff[16] ? 16'(-diff) : 16'(diff);
		end
		// A skipped move keeps the base, which is the measured position the
		// first time the target is taken.
		if (ctl.commit) begin
			if (ctl.active) begin
				held_q <= ctl.arm_send ? tgt_q : base_q;
			end else begin
				held_q <= meas;
			end
		end
	end

	assign nz    = nz_s4;
	assign adiff = adiff_q;
	assign tgt   = tgt_q;

endmodule

// ----- hdl/jjji_merge.sv -----
// ----------------------------------------------------------------------------
// jjji_merge: combines the lane results of one tick
// Finds whether any lane moves and whether the largest joint change reaches
// the minimum goal step.
// ----------------------------------------------------------------------------
module jjji_merge #(
	parameter int LANES = 5
) (
	input  logic [LANES-1:0][15:0] adiff,
	input  logic [LANES-1:0]       nz,
	input  logic [11:0]            min_step,
	output jjji_pkg::jjji_merge_t  res
);
	import jjji_pkg::*;

	logic [15:0] maxd;

	always_comb begin
		maxd = '0;
		for (int i = 0; i < LANES; i++) begin
			if (adiff[i] > maxd) begin
				maxd = adiff[i];
			end
		end
		res.active = |nz;
		res.reach  = (maxd >= {4'b0000, min_step});
	end

endmodule
